// ----- rtl/rubi_pkg.sv -----
// ----------------------------------------------------------------------------
// rubi_pkg
// Shared types, widths and constants of the ray / unit box intersect pipeline.
// ----------------------------------------------------------------------------
package rubi_pkg;

  localparam int FRAC_BITS = 16;

  // magnitude of (plane - origin) * ONE
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int SLAB_LAT  = DIV_LAT + 1;
  localparam int HIT_LAT   = 6;
  localparam int FACE_LAT  = 5;
  localparam int PIPE_LAT  = 1 + SLAB_LAT + HIT_LAT + FACE_LAT;

  localparam int EPS_W  = 17;
  localparam int TEX_W  = 17;
  localparam int FACE_W = 3;
  localparam int UV_W   = FRAC_BITS + 1;
  localparam int VX_W   = FRAC_BITS + 2;

  // v / 3 by reciprocal, result low by at most one
  localparam int DIV3_S = VX_W + 2;
  localparam logic [DIV3_S-1:0] DIV3_REC = DIV3_S'((64'd1 << DIV3_S) / 64'd3);

  localparam int TEX_SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int TEX_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic signed [33:0] ONE_Q  = 34'sd1 <<< FRAC_BITS;
  localparam logic signed [33:0] ONE2_Q = ONE_Q <<< 1;
  localparam logic signed [33:0] ONE3_Q = ONE_Q + (ONE_Q <<< 1);
  localparam logic signed [33:0] ONE4_Q = ONE_Q <<< 2;

  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

  localparam logic [FACE_W-1:0] FACE_NX   = 3'd0;
  localparam logic [FACE_W-1:0] FACE_PX   = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NY   = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PY   = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NZ   = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PZ   = 3'd5;
  localparam logic [FACE_W-1:0] FACE_NONE = 3'd6;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic signed [31:0] tmin;
    logic signed [31:0] tmax;
  } ray_t;

  typedef struct packed {
    logic signed [31:0] tn;
    logic signed [31:0] tf;
    logic               par;
    logic               par_ok;
  } slab_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] th;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } hit_t;

  function automatic logic [TEX_W-1:0] tex_scale(input logic [UV_W-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    w = (w >> TEX_SHR) << TEX_SHL;
    return w[TEX_W-1:0];
  endfunction

endpackage

// ----- rtl/ray_unit_box_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_unit_box_intersect
// Slab test of an object-space ray against the unit cube, with hit point,
// face code and cube-map u,v.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  request   | start / busy       | origin_x/y/z, dir_x/y/z, t_min, t_max
//  result    | done (one cycle)   | hit, t_hit, point_x/y/z, face, tex_u/v
//  config    | cfg_write          | cfg_data (face epsilon, unsigned Q1.16)
//
//  One request per cycle while busy is low. The pipeline depth comes mostly
//  from the 32-stage restoring dividers for the plane distances, six of
//  them running side by side.
//  Synchronous reset clears the valid bits and sets the epsilon to 66;
//  busy is high only during reset. Results cannot be held off.
// ----------------------------------------------------------------------------
module ray_unit_box_intersect (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              origin_x,
  input  logic signed [31:0]              origin_y,
  input  logic signed [31:0]              origin_z,
  input  logic signed [31:0]              dir_x,
  input  logic signed [31:0]              dir_y,
  input  logic signed [31:0]              dir_z,
  input  logic signed [31:0]              t_min,
  input  logic signed [31:0]              t_max,
  input  logic                            cfg_write,
  input  logic [rubi_pkg::EPS_W-1:0]      cfg_data,
  output logic                            done,
  output logic                            hit,
  output logic signed [31:0]              t_hit,
  output logic signed [31:0]              point_x,
  output logic signed [31:0]              point_y,
  output logic signed [31:0]              point_z,
  output logic [rubi_pkg::FACE_W-1:0]     face,
  output logic [rubi_pkg::TEX_W-1:0]      tex_u,
  output logic [rubi_pkg::TEX_W-1:0]      tex_v
);

  localparam int L = rubi_pkg::SLAB_LAT;
  localparam logic [rubi_pkg::EPS_W-1:0] EPS_RESET = 17'd66;

  logic [rubi_pkg::EPS_W-1:0] eps;
  logic                       v0;
  rubi_pkg::ray_t             ray0;
  rubi_pkg::ray_t             ray_d [0:L-1];
  logic                       vsx, vsy, vsz;
  rubi_pkg::slab_t            sx, sy, sz;
  logic                       vh;
  rubi_pkg::hit_t             hres;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= EPS_RESET;
      v0  <= 1'b0;
    end else begin
      if (cfg_write) begin
        eps <= cfg_data;
      end
      v0 <= start && !busy;
    end
    ray0 <= '{ox: origin_x, oy: origin_y, oz: origin_z,
               dx: dir_x, dy: dir_y, dz: dir_z, tmin: t_min, tmax: t_max};
    ray_d[0] <= ray0;
  end

  for (genvar i = 1; i < L; i++) begin : g_ray
    always_ff @(posedge clk) begin
      ray_d[i] <= ray_d[i-1];
    end
  end

  rubi_slab u_slab_x (
    .clk (clk), .rst (rst), .in_valid (v0), .o (ray0.ox), .d (ray0.dx),
    .out_valid (vsx), .res (sx)
  );

  rubi_slab u_slab_y (
    .clk (clk), .rst (rst), .in_valid (v0), .o (ray0.oy), .d (ray0.dy),
    .out_valid (vsy), .res (sy)
  );

  rubi_slab u_slab_z (
    .clk (clk), .rst (rst), .in_valid (v0), .o (ray0.oz), .d (ray0.dz),
    .out_valid (vsz), .res (sz)
  );

  rubi_hit u_hit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vsx && vsy && vsz),
    .ray       (ray_d[L-1]),
    .sx        (sx),
    .sy        (sy),
    .sz        (sz),
    .out_valid (vh),
    .res       (hres)
  );

  rubi_face u_face (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vh),
    .h        (hres),
    .eps      (eps),
    .done     (done),
    .hit      (hit),
    .t_hit    (t_hit),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .face     (face),
    .tex_u    (tex_u),
    .tex_v    (tex_v)
  );

  // every result traces back to a request a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, rubi_pkg::PIPE_LAT))
    else $error("result without matching request");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> face == rubi_pkg::FACE_NONE && t_hit == 32'sd0 &&
                     tex_u == '0 && tex_v == '0)
    else $error("miss result not cleared");

  a_noface: assert property (@(posedge clk) disable iff (rst)
    done && face == rubi_pkg::FACE_NONE |-> tex_u == '0 && tex_v == '0)
    else $error("texture coordinates without a face");

endmodule

// ----- rtl/rubi_div.sv -----
// ----------------------------------------------------------------------------
// rubi_div
// Pipelined restoring divider, one quotient bit per stage, signed and
// saturated to 32 bits, truncated toward zero.
// ----------------------------------------------------------------------------
module rubi_div (
  input  logic                       clk,
  input  logic [rubi_pkg::NUM_W-1:0] num_mag,
  input  logic                       num_neg,
  input  logic [31:0]                den_mag,
  input  logic                       den_neg,
  output logic signed [31:0]         q
);

  localparam int N = rubi_pkg::DIV_STEPS;

  logic [31:0] rem  [0:N-1];
  logic [31:0] lo   [0:N-1];
  logic [31:0] den  [0:N-1];
  logic [31:0] qacc [0:N];
  logic        ovf  [0:N];
  logic        neg  [0:N];
  logic [31:0] hi;
  logic [31:0] mag;

  assign hi = 32'(num_mag[rubi_pkg::NUM_W-1:32]);

  // quotient of 2^32 or more saturates, so the top bits seed the remainder
  always_ff @(posedge clk) begin
    rem[0]  <= hi;
    lo[0]   <= num_mag[31:0];
    den[0]  <= den_mag;
    qacc[0] <= '0;
    ovf[0]  <= (hi >= den_mag);
    neg[0]  <= num_neg ^ den_neg;
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [32:0] trial;
    logic        take;
    assign trial = {rem[i], lo[i][31]} - {1'b0, den[i]};
    assign take  = !trial[32];
    always_ff @(posedge clk) begin
      qacc[i+1] <= {qacc[i][30:0], take};
      ovf[i+1]  <= ovf[i];
      neg[i+1]  <= neg[i];
    end
    if (i < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[i+1] <= take ? trial[31:0] : {rem[i][30:0], lo[i][31]};
        lo[i+1]  <= {lo[i][30:0], 1'b0};
        den[i+1] <= den[i];
      end
    end
  end

  assign mag = qacc[N];

  always_ff @(posedge clk) begin
    if (neg[N]) begin
      if (ovf[N] || mag > 32'h8000_0000) begin
        q <= rubi_pkg::INT_MIN;
      end else begin
        q <= 32'sd0 - $signed(mag);
      end
    end else begin
      if (ovf[N] || mag[31]) begin
        q <= rubi_pkg::INT_MAX;
      end else begin
        q <= $signed(mag);
      end
    end
  end

endmodule

// ----- rtl/rubi_slab.sv -----
// ----------------------------------------------------------------------------
// rubi_slab
// Near and far plane distances of one axis of the unit cube.
// ----------------------------------------------------------------------------
module rubi_slab (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [31:0]  o,
  input  logic signed [31:0]  d,
  output logic                out_valid,
  output rubi_pkg::slab_t     res
);

  localparam int L = rubi_pkg::DIV_LAT;

  logic [31:0]              o_mag;
  logic signed [33:0]       f;
  logic [33:0]              f_mag;
  logic [rubi_pkg::NUM_W-1:0] near_mag;
  logic [rubi_pkg::NUM_W-1:0] far_mag;
  logic                     near_neg;
  logic                     far_neg;
  logic [31:0]              d_mag;
  logic                     d_neg;
  logic                     v1;
  logic                     vd     [0:L-1];
  // parallel flags are taken one stage earlier than the valid chain
  logic                     par_d  [0:L];
  logic                     pok_d  [0:L];
  logic signed [31:0]       q_near;
  logic signed [31:0]       q_far;

  assign o_mag = o[31] ? (~o + 32'd1) : o;
  assign f     = rubi_pkg::ONE_Q - 34'(o);
  assign f_mag = f[33] ? (~f + 34'd1) : f;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
    near_mag <= rubi_pkg::NUM_W'(o_mag) << rubi_pkg::FRAC_BITS;
    near_neg <= !o[31] && (o != 32'sd0);
    far_mag  <= rubi_pkg::NUM_W'(f_mag[31:0]) << rubi_pkg::FRAC_BITS;
    far_neg  <= f[33];
    d_mag    <= d[31] ? (~d + 32'd1) : d;
    d_neg    <= d[31];
    par_d[0] <= (d == 32'sd0);
    pok_d[0] <= !o[31] && (34'(o) <= rubi_pkg::ONE_Q);
  end

  rubi_div u_near (
    .clk     (clk),
    .num_mag (near_mag),
    .num_neg (near_neg),
    .den_mag (d_mag),
    .den_neg (d_neg),
    .q       (q_near)
  );

  rubi_div u_far (
    .clk     (clk),
    .num_mag (far_mag),
    .num_neg (far_neg),
    .den_mag (d_mag),
    .den_neg (d_neg),
    .q       (q_far)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else begin
      vd[0] <= v1;
    end
  end

  for (genvar i = 1; i < L; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[i] <= 1'b0;
      end else begin
        vd[i] <= vd[i-1];
      end
    end
  end

  for (genvar i = 1; i <= L; i++) begin : g_par
    always_ff @(posedge clk) begin
      par_d[i] <= par_d[i-1];
      pok_d[i] <= pok_d[i-1];
    end
  end

  assign out_valid  = vd[L-1];
  assign res.tn     = q_near;
  assign res.tf     = q_far;
  assign res.par    = par_d[L];
  assign res.par_ok = pok_d[L];

endmodule

// ----- rtl/rubi_hit.sv -----
// ----------------------------------------------------------------------------
// rubi_hit
// Merges the three slabs into entry and exit t, picks the hit distance and
// forms the hit point.
// ----------------------------------------------------------------------------
module rubi_hit (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rubi_pkg::ray_t  ray,
  input  rubi_pkg::slab_t sx,
  input  rubi_pkg::slab_t sy,
  input  rubi_pkg::slab_t sz,
  output logic            out_valid,
  output rubi_pkg::hit_t  res
);

  rubi_pkg::slab_t    s [0:2];
  logic signed [31:0] lo_c [0:2];
  logic signed [31:0] hi_c [0:2];
  logic [2:0]         bad;

  logic [5:0]         v;
  rubi_pkg::ray_t     r1, r2, r3, r4, r5;
  logic signed [31:0] lo1 [0:2];
  logic signed [31:0] hi1 [0:2];
  logic               fail1, fail2, fail3;
  logic signed [31:0] a0, a1, b0, b1;
  logic signed [31:0] t0, t1;
  logic               ok4, ok5;
  logic signed [31:0] th4, th5;
  logic signed [63:0] prod [0:2];
  logic signed [63:0] sum  [0:2];
  logic               c0, c1;

  assign s[0] = sx;
  assign s[1] = sy;
  assign s[2] = sz;

  // a parallel axis adds no bounds
  for (genvar a = 0; a < 3; a++) begin : g_axis
    always_comb begin
      if (s[a].par) begin
        lo_c[a] = rubi_pkg::INT_MIN;
        hi_c[a] = rubi_pkg::INT_MAX;
      end else if (s[a].tn > s[a].tf) begin
        lo_c[a] = s[a].tf;
        hi_c[a] = s[a].tn;
      end else begin
        lo_c[a] = s[a].tn;
        hi_c[a] = s[a].tf;
      end
    end
    assign bad[a] = s[a].par && !s[a].par_ok;
  end

  assign c0 = (t0 > r3.tmin) && (t0 < r3.tmax);
  assign c1 = (t1 > r3.tmin) && (t1 < r3.tmax);

  assign sum[0] = 64'(r5.ox) + (prod[0] >>> rubi_pkg::FRAC_BITS);
  assign sum[1] = 64'(r5.oy) + (prod[1] >>> rubi_pkg::FRAC_BITS);
  assign sum[2] = 64'(r5.oz) + (prod[2] >>> rubi_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[4:0], in_valid};
    end
    // bounds per axis
    r1    <= ray;
    lo1   <= lo_c;
    hi1   <= hi_c;
    fail1 <= |bad;
    // pairwise max / min
    r2    <= r1;
    fail2 <= fail1;
    a0    <= (lo1[0] > r1.tmin) ? lo1[0] : r1.tmin;
    a1    <= (lo1[1] > lo1[2]) ? lo1[1] : lo1[2];
    b0    <= (hi1[0] < r1.tmax) ? hi1[0] : r1.tmax;
    b1    <= (hi1[1] < hi1[2]) ? hi1[1] : hi1[2];
    // entry / exit
    r3    <= r2;
    fail3 <= fail2;
    t0    <= (a0 > a1) ? a0 : a1;
    t1    <= (b0 < b1) ? b0 : b1;
    // hit distance
    r4    <= r3;
    ok4   <= !fail3 && !(t0 > t1) && (c0 || c1);
    th4   <= c0 ? t0 : (c1 ? t1 : 32'sd0);
    // products
    r5      <= r4;
    ok5     <= ok4;
    th5     <= th4;
    prod[0] <= 64'(r4.dx) * 64'(th4);
    prod[1] <= 64'(r4.dy) * 64'(th4);
    prod[2] <= 64'(r4.dz) * 64'(th4);
    // hit point with saturation
    res.ok <= ok5;
    res.th <= th5;
    res.px <= (sum[0] > 64'(rubi_pkg::INT_MAX)) ? rubi_pkg::INT_MAX :
              (sum[0] < 64'(rubi_pkg::INT_MIN)) ? rubi_pkg::INT_MIN : sum[0][31:0];
    res.py <= (sum[1] > 64'(rubi_pkg::INT_MAX)) ? rubi_pkg::INT_MAX :
              (sum[1] < 64'(rubi_pkg::INT_MIN)) ? rubi_pkg::INT_MIN : sum[1][31:0];
    res.pz <= (sum[2] > 64'(rubi_pkg::INT_MAX)) ? rubi_pkg::INT_MAX :
              (sum[2] < 64'(rubi_pkg::INT_MIN)) ? rubi_pkg::INT_MIN : sum[2][31:0];
  end

  assign out_valid = v[5];

endmodule

// ----- rtl/rubi_face.sv -----
// ----------------------------------------------------------------------------
// rubi_face
// Face test on the hit point and cube-map texture coordinates; drives the
// result registers.
// ----------------------------------------------------------------------------
module rubi_face (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  rubi_pkg::hit_t                     h,
  input  logic [rubi_pkg::EPS_W-1:0]         eps,
  output logic                               done,
  output logic                               hit,
  output logic signed [31:0]                 t_hit,
  output logic signed [31:0]                 point_x,
  output logic signed [31:0]                 point_y,
  output logic signed [31:0]                 point_z,
  output logic [rubi_pkg::FACE_W-1:0]        face,
  output logic [rubi_pkg::TEX_W-1:0]         tex_u,
  output logic [rubi_pkg::TEX_W-1:0]         tex_v
);

  localparam int UW = rubi_pkg::UV_W;
  localparam int XW = rubi_pkg::VX_W;
  localparam int PW = XW + rubi_pkg::DIV3_S;

  logic signed [33:0] e;
  logic signed [33:0] pc [0:2];
  logic [5:0]         on_c;

  logic [3:0]         v;
  rubi_pkg::hit_t     h1, h2, h3, h4;
  logic [5:0]         on1;
  logic [rubi_pkg::FACE_W-1:0] fc_c, f2, f3, f4;
  logic signed [33:0] un_c, vn_c, un2, vn2, ush;
  logic [UW-1:0]      u3, u4;
  logic [XW-1:0]      vx3, vx4;
  logic [PW-1:0]      prod;
  logic [UW-1:0]      q0;
  logic [XW-1:0]      rem3;
  logic [UW-1:0]      vq;

  assign e     = 34'($unsigned(eps));
  assign pc[0] = 34'(h.px);
  assign pc[1] = 34'(h.py);
  assign pc[2] = 34'(h.pz);

  // |p - plane| < eps written as a window
  for (genvar a = 0; a < 3; a++) begin : g_on
    assign on_c[2*a]   = (pc[a] < e) && (pc[a] > -e);
    assign on_c[2*a+1] = (pc[a] < rubi_pkg::ONE_Q + e) && (pc[a] > rubi_pkg::ONE_Q - e);
  end

  always_comb begin
    if (on1[0])      fc_c = rubi_pkg::FACE_NX;
    else if (on1[1]) fc_c = rubi_pkg::FACE_PX;
    else if (on1[2]) fc_c = rubi_pkg::FACE_NY;
    else if (on1[3]) fc_c = rubi_pkg::FACE_PY;
    else if (on1[4]) fc_c = rubi_pkg::FACE_NZ;
    else if (on1[5]) fc_c = rubi_pkg::FACE_PZ;
    else             fc_c = rubi_pkg::FACE_NONE;
  end

  always_comb begin
    unique case (fc_c)
      rubi_pkg::FACE_NX: begin
        un_c = rubi_pkg::ONE_Q - 34'(h1.pz);
        vn_c = rubi_pkg::ONE_Q + 34'(h1.py);
      end
      rubi_pkg::FACE_PX: begin
        un_c = rubi_pkg::ONE2_Q + 34'(h1.pz);
        vn_c = rubi_pkg::ONE_Q + 34'(h1.py);
      end
      rubi_pkg::FACE_NY: begin
        un_c = rubi_pkg::ONE_Q + 34'(h1.px);
        vn_c = rubi_pkg::ONE_Q - 34'(h1.pz);
      end
      rubi_pkg::FACE_PY: begin
        un_c = rubi_pkg::ONE_Q + 34'(h1.px);
        vn_c = rubi_pkg::ONE2_Q + 34'(h1.pz);
      end
      rubi_pkg::FACE_NZ: begin
        un_c = rubi_pkg::ONE_Q + 34'(h1.px);
        vn_c = rubi_pkg::ONE_Q + 34'(h1.py);
      end
      rubi_pkg::FACE_PZ: begin
        un_c = rubi_pkg::ONE4_Q - 34'(h1.px);
        vn_c = rubi_pkg::ONE_Q + 34'(h1.py);
      end
      default: begin
        un_c = '0;
        vn_c = '0;
      end
    endcase
  end

  assign ush  = un2 >>> 2;
  assign q0   = UW'(prod >> rubi_pkg::DIV3_S);
  assign rem3 = vx4 - (XW'(q0) + (XW'(q0) << 1));
  assign vq   = (rem3 >= XW'(3)) ? q0 + UW'(1) : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v    <= '0;
      done <= 1'b0;
    end else begin
      v    <= {v[2:0], in_valid};
      done <= v[3];
    end
    // plane windows
    h1  <= h;
    on1 <= on_c;
    // face and coordinate sums
    h2  <= h1;
    f2  <= fc_c;
    un2 <= un_c;
    vn2 <= vn_c;
    // clamps; v is clamped before the divide by three
    h3 <= h2;
    f3 <= f2;
    if (ush < 0) begin
      u3 <= '0;
    end else if (ush > rubi_pkg::ONE_Q) begin
      u3 <= rubi_pkg::ONE_Q[UW-1:0];
    end else begin
      u3 <= ush[UW-1:0];
    end
    if (vn2 < 0) begin
      vx3 <= '0;
    end else if (vn2 > rubi_pkg::ONE3_Q) begin
      vx3 <= rubi_pkg::ONE3_Q[XW-1:0];
    end else begin
      vx3 <= vn2[XW-1:0];
    end
    // reciprocal product
    h4   <= h3;
    f4   <= f3;
    u4   <= u3;
    vx4  <= vx3;
    prod <= PW'(vx3) * PW'(rubi_pkg::DIV3_REC);
    // result
    if (!h4.ok) begin
      hit     <= 1'b0;
      t_hit   <= '0;
      point_x <= '0;
      point_y <= '0;
      point_z <= '0;
      face    <= rubi_pkg::FACE_NONE;
      tex_u   <= '0;
      tex_v   <= '0;
    end else begin
      hit     <= 1'b1;
      t_hit   <= h4.th;
      point_x <= h4.px;
      point_y <= h4.py;
      point_z <= h4.pz;
      face    <= f4;
      if (f4 == rubi_pkg::FACE_NONE) begin
        tex_u <= '0;
        tex_v <= '0;
      end else begin
        tex_u <= rubi_pkg::tex_scale(u4);
        tex_v <= rubi_pkg::tex_scale(vq);
      end
    end
  end

endmodule
